### rtl/pfac_pkg.sv
// ----------------------------------------------------------------------------
// pfac_pkg
// Shared types and constants for the printf format argument classifier.
// ----------------------------------------------------------------------------
package pfac_pkg;

  localparam int unsigned CountBitsDef = 16;
  localparam int unsigned PosW         = 16;
  localparam int unsigned MaxTypesW    = 16;
  localparam int unsigned CharW        = 8;
  localparam int unsigned QueueDepth   = 2;

  // format characters with a structural meaning
  localparam logic [CharW-1:0] CharNul     = 8'h00;
  localparam logic [CharW-1:0] CharPct     = 8'h25;  // '%'
  localparam logic [CharW-1:0] CharStar    = 8'h2a;  // '*'
  localparam logic [CharW-1:0] CharDot     = 8'h2e;  // '.'
  localparam logic [CharW-1:0] CharLong    = 8'h6c;  // 'l'
  localparam logic [CharW-1:0] CharQuad    = 8'h71;  // 'q'
  localparam logic [CharW-1:0] CharDigLo   = 8'h30;  // '0'
  localparam logic [CharW-1:0] CharDigHi   = 8'h39;  // '9'

  typedef enum logic [9:0] {
    PhText   = 10'b00_0000_0001,
    PhPct    = 10'b00_0000_0010,
    PhFlags  = 10'b00_0000_0100,
    PhWdig   = 10'b00_0000_1000,
    PhWdone  = 10'b00_0001_0000,
    PhPstart = 10'b00_0010_0000,
    PhPdig   = 10'b00_0100_0000,
    PhLen    = 10'b00_1000_0000,
    PhLong1  = 10'b01_0000_0000,
    PhConv   = 10'b10_0000_0000
  } pfac_phase_e;

  typedef enum logic [2:0] {
    ArgInt     = 3'd0,
    ArgChar    = 3'd1,
    ArgString  = 3'd2,
    ArgPointer = 3'd3,
    ArgDouble  = 3'd5
  } pfac_arg_e;

  typedef enum logic {
    KindArg = 1'b0,
    KindEnd = 1'b1
  } pfac_kind_e;

  // one queue entry: everything one format byte produces
  typedef struct packed {
    logic              has_arg;
    pfac_arg_e         arg_type;
    logic              long_flag;
    logic [PosW-1:0]   arg_pos;
    logic              stored;
    logic              has_end;
    logic [PosW-1:0]   end_pos;
  } pfac_entry_t;

  // queue status seen by the front
  typedef struct packed {
    logic full;
    logic empty;
  } pfac_qstat_t;

endpackage

### rtl/printf_format_arg_classifier.sv
// ----------------------------------------------------------------------------
// printf_format_arg_classifier
// Streams a printf format string and reports the type of every argument.
// ----------------------------------------------------------------------------
// Usage:
//   Feed the format string one byte per request on s_axis; a zero byte ends
//   the string. Each star width, star precision and conversion yields one
//   argument record on m_axis (type, long flag, position, stored flag); a
//   zero byte yields an end record carrying the total argument count,
//   preceded by a plain int record when a spec was left open. tlast marks
//   the last record caused by one input byte.
//   cfg_we_i/cfg_wdata_i load max_types (capacity of the caller's array);
//   write it only while the block is idle.
// Timing:
//   One byte per cycle is accepted while the queue is not full. A record
//   reaches m_axis through the queue, written at the accepting edge, and
//   the output register, loaded from the queue head when empty or drained.
//   A byte that yields two records stays at the queue head until both are
//   loaded; a producing byte right behind it fills the queue and the input waits.
// Reset and stall:
//   Reset returns to the text phase with a zero count and max_types zero.
//   When m_axis stalls the output register holds, the queue fills, and
//   s_axis_tready drops once both queue entries are taken.
// ----------------------------------------------------------------------------
module printf_format_arg_classifier #(
  parameter int unsigned COUNT_BITS = pfac_pkg::CountBitsDef
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [pfac_pkg::MaxTypesW-1:0]  cfg_wdata_i,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [7:0]                      s_axis_tdata,   // [7:0] format_char
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // [2:0] arg_type, [3] long_flag, [19:4] position, [20] stored, [23:21] zero
  output logic [23:0]                     m_axis_tdata,
  output logic                            m_axis_tuser,   // [0] record_kind
  output logic                            m_axis_tlast    // last_result
);

  pfac_pkg::pfac_entry_t  push_entry, head_entry;
  pfac_pkg::pfac_qstat_t  qstat;
  logic                   push, pop;
  pfac_pkg::pfac_kind_e   out_kind;
  pfac_pkg::pfac_arg_e    out_type;
  logic                   out_long, out_stored;
  logic [pfac_pkg::PosW-1:0] out_pos;

  // front: track the parse phase, count arguments, build entries
  pfac_front #(
    .COUNT_BITS (COUNT_BITS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_char_i   (s_axis_tdata),
    .qstat_i     (qstat),
    .push_o      (push),
    .entry_o     (push_entry)
  );

  pfac_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_entry),
    .pop_i       (pop),
    .head_o      (head_entry),
    .qstat_o     (qstat)
  );

  // back: expand each entry into its records behind the output register
  pfac_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_i       (head_entry),
    .head_valid_i (!qstat.empty),
    .pop_o        (pop),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_kind_o   (out_kind),
    .out_type_o   (out_type),
    .out_long_o   (out_long),
    .out_pos_o    (out_pos),
    .out_stored_o (out_stored),
    .out_last_o   (m_axis_tlast)
  );

  assign m_axis_tdata = {3'b000, out_stored, out_pos, out_long, out_type};
  assign m_axis_tuser = out_kind;

`ifndef SYNTHESIS
  // an end record always closes the results of its byte
  a_end_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser) |-> m_axis_tlast)
    else $error("end record without tlast");

  // an end record carries no type, long flag or stored flag
  a_end_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata[3:0] == 4'h0 && !m_axis_tdata[20]))
    else $error("end record carries argument fields");

  // only a flushed int may precede an end record within one byte
  a_first_of_pair: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tlast) |->
      (!m_axis_tuser && m_axis_tdata[3:0] == 4'h0))
    else $error("unexpected record ahead of end record");

  // a held record is not replaced before it is taken
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
    else $error("output record changed while stalled");
`endif

endmodule

### rtl/pfac_front.sv
// ----------------------------------------------------------------------------
// pfac_front
// Parse phase tracker: classifies each format byte and builds queue entries.
// ----------------------------------------------------------------------------
module pfac_front #(
  parameter int unsigned COUNT_BITS = pfac_pkg::CountBitsDef
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [pfac_pkg::MaxTypesW-1:0]  cfg_wdata_i,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [pfac_pkg::CharW-1:0]      in_char_i,
  input  pfac_pkg::pfac_qstat_t           qstat_i,
  output logic                            push_o,
  output pfac_pkg::pfac_entry_t           entry_o
);

  localparam int unsigned CmpW = (COUNT_BITS > pfac_pkg::PosW) ? COUNT_BITS : pfac_pkg::PosW;
  localparam logic [COUNT_BITS-1:0] CntMax = {COUNT_BITS{1'b1}};

  pfac_pkg::pfac_phase_e phase_q, phase_d, ph;
  logic                            long_q, long_d;
  logic [COUNT_BITS-1:0]           cnt_q, cnt_d, cnt_inc;
  logic [pfac_pkg::MaxTypesW-1:0]  max_types_q;
  logic                            accept, in_spec, done, emit, end_rec, lng, is_dig;
  pfac_pkg::pfac_arg_e             typ;
  logic [CmpW-1:0]                 cnt_ext, end_ext;
  logic [pfac_pkg::CharW-1:0]      c;

  assign in_ready_o = !qstat_i.full;
  assign accept     = in_valid_i && in_ready_o;
  assign c          = in_char_i;
  assign is_dig     = (c >= pfac_pkg::CharDigLo) && (c <= pfac_pkg::CharDigHi);
  assign in_spec    = (phase_q == pfac_pkg::PhPct)    || (phase_q == pfac_pkg::PhFlags) ||
                      (phase_q == pfac_pkg::PhWdig)   || (phase_q == pfac_pkg::PhWdone) ||
                      (phase_q == pfac_pkg::PhPstart) || (phase_q == pfac_pkg::PhPdig)  ||
                      (phase_q == pfac_pkg::PhLen)    || (phase_q == pfac_pkg::PhLong1) ||
                      (phase_q == pfac_pkg::PhConv);
  assign cnt_inc    = (cnt_q == CntMax) ? cnt_q : cnt_q + COUNT_BITS'(1);

  always_comb begin
    ph      = phase_q;
    phase_d = phase_q;
    long_d  = long_q;
    done    = 1'b0;
    emit    = 1'b0;
    end_rec = 1'b0;
    typ     = pfac_pkg::ArgInt;
    lng     = 1'b0;
    if (c == pfac_pkg::CharNul) begin
      // flush an open spec as plain int, then close the string
      emit    = in_spec;
      end_rec = 1'b1;
      phase_d = pfac_pkg::PhText;
      long_d  = 1'b0;
    end else if (!in_spec) begin
      if (c == pfac_pkg::CharPct) begin
        phase_d = pfac_pkg::PhPct;
        long_d  = 1'b0;
      end else begin
        phase_d = pfac_pkg::PhText;
      end
    end else begin
      if (ph == pfac_pkg::PhPct) begin
        if (c == pfac_pkg::CharPct) begin
          phase_d = pfac_pkg::PhText;
          done    = 1'b1;
        end else begin
          ph = pfac_pkg::PhFlags;
        end
      end
      if (!done && ph == pfac_pkg::PhFlags) begin
        if (c == "-" || c == "+" || c == " " || c == "#" || c == "0" || c == "'") begin
          phase_d = pfac_pkg::PhFlags;
          done    = 1'b1;
        end else if (c == pfac_pkg::CharStar) begin
          phase_d = pfac_pkg::PhWdone;
          emit    = 1'b1;
          done    = 1'b1;
        end else if (is_dig) begin
          phase_d = pfac_pkg::PhWdig;
          done    = 1'b1;
        end else begin
          ph = pfac_pkg::PhWdone;
        end
      end
      if (!done && ph == pfac_pkg::PhWdig) begin
        if (is_dig) begin
          phase_d = pfac_pkg::PhWdig;
          done    = 1'b1;
        end else begin
          ph = pfac_pkg::PhWdone;
        end
      end
      if (!done && ph == pfac_pkg::PhWdone) begin
        if (c == pfac_pkg::CharDot) begin
          phase_d = pfac_pkg::PhPstart;
          done    = 1'b1;
        end else begin
          ph = pfac_pkg::PhLen;
        end
      end
      if (!done && ph == pfac_pkg::PhPstart) begin
        if (c == pfac_pkg::CharStar) begin
          phase_d = pfac_pkg::PhLen;
          emit    = 1'b1;
          done    = 1'b1;
        end else if (is_dig) begin
          phase_d = pfac_pkg::PhPdig;
          done    = 1'b1;
        end else begin
          ph = pfac_pkg::PhLen;
        end
      end
      if (!done && ph == pfac_pkg::PhPdig) begin
        if (is_dig) begin
          phase_d = pfac_pkg::PhPdig;
          done    = 1'b1;
        end else begin
          ph = pfac_pkg::PhLen;
        end
      end
      if (!done && ph == pfac_pkg::PhLen) begin
        if (c == pfac_pkg::CharLong) begin
          long_d  = 1'b1;
          phase_d = pfac_pkg::PhLong1;
          done    = 1'b1;
        end else if (c == "h" || c == "L" || c == "z" || c == "j" || c == "t" ||
                     c == pfac_pkg::CharQuad) begin
          phase_d = pfac_pkg::PhConv;
          done    = 1'b1;
        end else begin
          ph = pfac_pkg::PhConv;
        end
      end
      if (!done && ph == pfac_pkg::PhLong1) begin
        if (c == pfac_pkg::CharLong) begin
          phase_d = pfac_pkg::PhConv;
          done    = 1'b1;
        end
      end
      if (!done) begin
        // conversion byte: decode the argument type
        unique case (c) inside
          "d", "i", "o", "u", "x", "X": lng = long_q;
          "s": typ = pfac_pkg::ArgString;
          "p": typ = pfac_pkg::ArgPointer;
          "c": typ = pfac_pkg::ArgChar;
          "f", "F", "e", "E", "g", "G", "a", "A": typ = pfac_pkg::ArgDouble;
          "n": lng = 1'b1;
          default: typ = pfac_pkg::ArgInt;
        endcase
        emit    = 1'b1;
        long_d  = 1'b0;
        phase_d = pfac_pkg::PhText;
      end
    end
  end

  always_comb begin
    if (end_rec) begin
      cnt_d = '0;
    end else if (emit) begin
      cnt_d = cnt_inc;
    end else begin
      cnt_d = cnt_q;
    end
  end

  assign cnt_ext = CmpW'(cnt_q);
  assign end_ext = emit ? CmpW'(cnt_inc) : CmpW'(cnt_q);

  always_comb begin
    entry_o.has_arg   = emit;
    entry_o.arg_type  = typ;
    entry_o.long_flag = lng;
    entry_o.arg_pos   = cnt_ext[pfac_pkg::PosW-1:0];
    entry_o.stored    = cnt_ext < CmpW'(max_types_q);
    entry_o.has_end   = end_rec;
    entry_o.end_pos   = end_ext[pfac_pkg::PosW-1:0];
  end

  assign push_o = accept && (emit || end_rec);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= pfac_pkg::PhText;
      long_q      <= 1'b0;
      cnt_q       <= '0;
      max_types_q <= '0;
    end else begin
      if (accept) begin
        phase_q <= phase_d;
        long_q  <= long_d;
        cnt_q   <= cnt_d;
      end
      if (cfg_we_i) begin
        max_types_q <= cfg_wdata_i;
      end
    end
  end

endmodule

### rtl/pfac_queue.sv
// ----------------------------------------------------------------------------
// pfac_queue
// Two-entry queue that decouples the parser from the record emitter.
// ----------------------------------------------------------------------------
module pfac_queue (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   push_i,
  input  pfac_pkg::pfac_entry_t  push_data_i,
  input  logic                   pop_i,
  output pfac_pkg::pfac_entry_t  head_o,
  output pfac_pkg::pfac_qstat_t  qstat_o
);

  localparam int unsigned PtrW = $clog2(pfac_pkg::QueueDepth);
  localparam int unsigned CntW = $clog2(pfac_pkg::QueueDepth + 1);

  pfac_pkg::pfac_entry_t slots_q [pfac_pkg::QueueDepth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] fill_q;
  logic            do_push, do_pop;

  assign qstat_o.full  = (fill_q == CntW'(pfac_pkg::QueueDepth));
  assign qstat_o.empty = (fill_q == '0);
  assign do_push       = push_i && !qstat_o.full;
  assign do_pop        = pop_i && !qstat_o.empty;
  assign head_o        = slots_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slots_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + PtrW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + PtrW'(1);
      end
      if (do_push && !do_pop) begin
        fill_q <= fill_q + CntW'(1);
      end else if (do_pop && !do_push) begin
        fill_q <= fill_q - CntW'(1);
      end
    end
  end

endmodule

### rtl/pfac_back.sv
// ----------------------------------------------------------------------------
// pfac_back
// Record emitter: expands queue entries into one or two output records.
// ----------------------------------------------------------------------------
module pfac_back (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  pfac_pkg::pfac_entry_t  head_i,
  input  logic                   head_valid_i,
  output logic                   pop_o,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output pfac_pkg::pfac_kind_e   out_kind_o,
  output pfac_pkg::pfac_arg_e    out_type_o,
  output logic                   out_long_o,
  output logic [pfac_pkg::PosW-1:0] out_pos_o,
  output logic                   out_stored_o,
  output logic                   out_last_o
);

  logic                       valid_q, valid_d, half_q, half_d, load, arg_part;
  pfac_pkg::pfac_kind_e       kind_q, kind_d;
  pfac_pkg::pfac_arg_e        type_q, type_d;
  logic                       long_q, long_d, stored_q, stored_d, last_q, last_d;
  logic [pfac_pkg::PosW-1:0]  pos_q, pos_d;

  // refill the output register when empty or being drained
  assign load     = !valid_q || out_ready_i;
  assign arg_part = head_i.has_arg && !half_q;

  always_comb begin
    valid_d  = valid_q;
    half_d   = half_q;
    pop_o    = 1'b0;
    kind_d   = kind_q;
    type_d   = type_q;
    long_d   = long_q;
    pos_d    = pos_q;
    stored_d = stored_q;
    last_d   = last_q;
    if (load) begin
      valid_d = head_valid_i;
      if (head_valid_i) begin
        if (arg_part) begin
          kind_d   = pfac_pkg::KindArg;
          type_d   = head_i.arg_type;
          long_d   = head_i.long_flag;
          pos_d    = head_i.arg_pos;
          stored_d = head_i.stored;
          last_d   = !head_i.has_end;
          half_d   = head_i.has_end;
          pop_o    = !head_i.has_end;
        end else begin
          kind_d   = pfac_pkg::KindEnd;
          type_d   = pfac_pkg::ArgInt;
          long_d   = 1'b0;
          pos_d    = head_i.end_pos;
          stored_d = 1'b0;
          last_d   = 1'b1;
          half_d   = 1'b0;
          pop_o    = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      half_q  <= 1'b0;
    end else begin
      valid_q <= valid_d;
      half_q  <= half_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q   <= kind_d;
    type_q   <= type_d;
    long_q   <= long_d;
    pos_q    <= pos_d;
    stored_q <= stored_d;
    last_q   <= last_d;
  end

  assign out_valid_o  = valid_q;
  assign out_kind_o   = kind_q;
  assign out_type_o   = type_q;
  assign out_long_o   = long_q;
  assign out_pos_o    = pos_q;
  assign out_stored_o = stored_q;
  assign out_last_o   = last_q;

endmodule

### tb/printf_format_arg_classifier_test.sv
// ----------------------------------------------------------------------------
// printf_format_arg_classifier_test
// Self-checking bench for the printf format argument classifier.
// ----------------------------------------------------------------------------
// A short table of format bytes runs first. Rows whose records are obvious
// carry hand-written expectations; all other rows are checked against a
// behavioral parser kept in this bench. Random format strings follow: mostly
// well-formed specs with random flags, widths, precisions, length modifiers
// and conversions, mixed with plain text and raw noise bytes. Each batch
// runs with its own max_types setting. Both sides idle at random but in one
// steady batch. The receiver once holds off to back up the input; the sender
// waits for all pending records at each max_types load and once mid-batch.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module printf_format_arg_classifier_test;

  // one record as seen on m_axis, unpacked into its fields
  typedef struct packed {
    logic        kind;
    logic [2:0]  arg;
    logic        lng;
    logic [15:0] pos;
    logic        stored;
    logic        last;
  } fmt_rec_t;

  // directed stimulus row; typed rows carry their records by hand
  typedef struct packed {
    logic [7:0] ch;
    logic       typed;
    logic [1:0] n_recs;
    fmt_rec_t   r0;
    fmt_rec_t   r1;
  } dir_row_t;

  localparam int unsigned NumDir   = 26;
  localparam int unsigned HoldOff  = 200;
  localparam int unsigned BatchLen = 130;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        cfg_we_i      = 1'b0;
  logic [15:0] cfg_wdata_i   = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata  = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;
  logic        m_axis_tuser;
  logic        m_axis_tlast;

  // parser state mirrored in the bench
  pfac_pkg::pfac_phase_e spec_phase = pfac_pkg::PhText;
  logic        long_seen  = 1'b0;
  logic [15:0] arg_cnt    = '0;
  logic [15:0] cap        = '0;
  fmt_rec_t    step_recs [2];
  int          n_step;

  fmt_rec_t    pending_recs [$];
  int          mismatches = 0;
  int          n_sent     = 0;
  bit          steady     = 1'b0;  // no idling on either side
  bit          hold_req   = 1'b0;  // ask the receiver for one long hold-off
  int          hold_left  = 0;

  // Stored flags assume max_types = 2 written right after reset.
  dir_row_t dir_plan [NumDir] = '{
    '{pfac_pkg::CharNul, 1'b1, 2'd1,
      '{pfac_pkg::KindEnd, pfac_pkg::ArgInt, 1'b0, 16'd0, 1'b0, 1'b1}, '0},
    '{pfac_pkg::CharPct, 1'b0, 2'd0, '0, '0},
    '{pfac_pkg::CharLong, 1'b0, 2'd0, '0, '0},
    '{"d", 1'b1, 2'd1,
      '{pfac_pkg::KindArg, pfac_pkg::ArgInt, 1'b1, 16'd0, 1'b1, 1'b1}, '0},
    '{pfac_pkg::CharPct, 1'b0, 2'd0, '0, '0},
    '{pfac_pkg::CharStar, 1'b1, 2'd1,
      '{pfac_pkg::KindArg, pfac_pkg::ArgInt, 1'b0, 16'd1, 1'b1, 1'b1}, '0},
    '{pfac_pkg::CharDot, 1'b0, 2'd0, '0, '0},
    '{pfac_pkg::CharStar, 1'b1, 2'd1,
      '{pfac_pkg::KindArg, pfac_pkg::ArgInt, 1'b0, 16'd2, 1'b0, 1'b1}, '0},
    '{"h", 1'b0, 2'd0, '0, '0},
    '{"h", 1'b0, 2'd0, '0, '0},          // second h is taken as a conversion
    '{pfac_pkg::CharPct, 1'b0, 2'd0, '0, '0},
    '{pfac_pkg::CharPct, 1'b0, 2'd0, '0, '0},      // percent-percent yields nothing
    '{pfac_pkg::CharPct, 1'b0, 2'd0, '0, '0},
    '{"-", 1'b0, 2'd0, '0, '0},
    '{"9", 1'b0, 2'd0, '0, '0},
    '{"s", 1'b0, 2'd0, '0, '0},
    '{pfac_pkg::CharPct, 1'b0, 2'd0, '0, '0},
    '{pfac_pkg::CharStar, 1'b0, 2'd0, '0, '0},
    '{"5", 1'b0, 2'd0, '0, '0},          // digit after star width converts
    '{pfac_pkg::CharPct, 1'b0, 2'd0, '0, '0},
    '{"L", 1'b0, 2'd0, '0, '0},
    '{"f", 1'b0, 2'd0, '0, '0},
    '{pfac_pkg::CharPct, 1'b0, 2'd0, '0, '0},
    '{8'hff, 1'b0, 2'd0, '0, '0},        // unknown conversion byte
    '{pfac_pkg::CharPct, 1'b0, 2'd0, '0, '0},
    '{pfac_pkg::CharNul, 1'b1, 2'd2,
      '{pfac_pkg::KindArg, pfac_pkg::ArgInt, 1'b0, 16'd9, 1'b0, 1'b0},
      '{pfac_pkg::KindEnd, pfac_pkg::ArgInt, 1'b0, 16'd10, 1'b0, 1'b1}}
  };

  printf_format_arg_classifier i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #5 clk_i = ~clk_i;

  // --------------------------------------------------------------------------
  // Format parser
  // --------------------------------------------------------------------------

  // Append one argument record and advance the count; saturate at the top.
  function automatic void emit_arg(input pfac_pkg::pfac_arg_e t, input logic lng);
    step_recs[n_step] = '{kind: pfac_pkg::KindArg, arg: t, lng: lng, pos: arg_cnt,
                          stored: arg_cnt < cap, last: 1'b0};
    n_step++;
    if (arg_cnt != 16'hffff) arg_cnt++;
  endfunction

  // Walk one non-NUL byte through the spec phases. A phase that does not
  // consume the byte hands it on to the next one, as the parser does.
  function automatic void advance_phase(input logic [7:0] ch);
    pfac_pkg::pfac_phase_e ph;
    pfac_pkg::pfac_arg_e   t;
    logic                  lng;
    logic                  dig;
    ph  = spec_phase;
    dig = (ch >= pfac_pkg::CharDigLo) && (ch <= pfac_pkg::CharDigHi);
    if (ph == pfac_pkg::PhText) begin
      if (ch == pfac_pkg::CharPct) begin
        spec_phase = pfac_pkg::PhPct;
        long_seen  = 1'b0;
      end
      return;
    end
    if (ph == pfac_pkg::PhPct) begin
      if (ch == pfac_pkg::CharPct) begin
        spec_phase = pfac_pkg::PhText;
        return;
      end
      ph = pfac_pkg::PhFlags;
    end
    if (ph == pfac_pkg::PhFlags) begin
      if (ch == "-" || ch == "+" || ch == " " || ch == "#" || ch == pfac_pkg::CharDigLo ||
          ch == "'") begin
        spec_phase = pfac_pkg::PhFlags;
        return;
      end
      if (ch == pfac_pkg::CharStar) begin
        spec_phase = pfac_pkg::PhWdone;
        emit_arg(pfac_pkg::ArgInt, 1'b0);
        return;
      end
      if (dig) begin
        spec_phase = pfac_pkg::PhWdig;
        return;
      end
      ph = pfac_pkg::PhWdone;
    end
    if (ph == pfac_pkg::PhWdig) begin
      if (dig) return;
      ph = pfac_pkg::PhWdone;
    end
    if (ph == pfac_pkg::PhWdone) begin
      if (ch == pfac_pkg::CharDot) begin
        spec_phase = pfac_pkg::PhPstart;
        return;
      end
      ph = pfac_pkg::PhLen;
    end
    if (ph == pfac_pkg::PhPstart) begin
      if (ch == pfac_pkg::CharStar) begin
        spec_phase = pfac_pkg::PhLen;
        emit_arg(pfac_pkg::ArgInt, 1'b0);
        return;
      end
      if (dig) begin
        spec_phase = pfac_pkg::PhPdig;
        return;
      end
      ph = pfac_pkg::PhLen;
    end
    if (ph == pfac_pkg::PhPdig) begin
      if (dig) return;
      ph = pfac_pkg::PhLen;
    end
    if (ph == pfac_pkg::PhLen) begin
      if (ch == pfac_pkg::CharLong) begin
        long_seen  = 1'b1;
        spec_phase = pfac_pkg::PhLong1;
        return;
      end
      // other length modifiers are skipped and never mark long
      if (ch == "h" || ch == "L" || ch == "z" || ch == "j" || ch == "t" ||
          ch == pfac_pkg::CharQuad) begin
        spec_phase = pfac_pkg::PhConv;
        return;
      end
      ph = pfac_pkg::PhConv;
    end
    if (ph == pfac_pkg::PhLong1) begin
      if (ch == pfac_pkg::CharLong) begin
        spec_phase = pfac_pkg::PhConv;
        return;
      end
    end
    // conversion byte: anything unknown falls back to a plain int
    t   = pfac_pkg::ArgInt;
    lng = 1'b0;
    case (ch)
      "d", "i", "o", "u", "x", "X": lng = long_seen;
      "s": t = pfac_pkg::ArgString;
      "p": t = pfac_pkg::ArgPointer;
      "c": t = pfac_pkg::ArgChar;
      "f", "F", "e", "E", "g", "G", "a", "A": t = pfac_pkg::ArgDouble;
      "n": lng = 1'b1;
      default: ;
    endcase
    emit_arg(t, lng);
    long_seen  = 1'b0;
    spec_phase = pfac_pkg::PhText;
  endfunction

  // Work out the records one accepted byte causes into step_recs.
  function automatic void classify_char(input logic [7:0] ch);
    n_step = 0;
    if (ch == pfac_pkg::CharNul) begin
      // flush an open spec as a plain int, then report the total
      if (spec_phase != pfac_pkg::PhText) emit_arg(pfac_pkg::ArgInt, 1'b0);
      step_recs[n_step] = '{kind: pfac_pkg::KindEnd, arg: pfac_pkg::ArgInt, lng: 1'b0,
                            pos: arg_cnt, stored: 1'b0, last: 1'b0};
      n_step++;
      spec_phase = pfac_pkg::PhText;
      long_seen  = 1'b0;
      arg_cnt    = '0;
    end else begin
      advance_phase(ch);
    end
    if (n_step > 0) step_recs[n_step-1].last = 1'b1;
  endfunction

  // --------------------------------------------------------------------------
  // Sender side
  // --------------------------------------------------------------------------

  // Offer one format byte, hold it until taken, then queue its records.
  // tvalid stays high on return so back-to-back requests need no toggle.
  task automatic feed_char(input logic [7:0] ch);
    while (!steady && $urandom_range(0, 99) < 29) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= ch;
    do @(posedge clk_i); while (!s_axis_tready);
    classify_char(ch);
    for (int i = 0; i < n_step; i++) pending_recs.push_back(step_recs[i]);
    n_sent++;
  endtask

  // Drop the request and wait until every queued record has come out, then
  // wait on so that a byte that produced nothing can clear the pipe.
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (pending_recs.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic load_max_types(input logic [15:0] v);
    settle();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    cap = v;
  endtask

  // One random format string: text runs, well-formed specs with random
  // content and raw noise bytes, always closed by a NUL.
  task automatic send_format();
    string      convs;
    string      flags;
    string      mods;
    int         r;
    logic [7:0] b;
    convs = "diouxXspcfFeEgGaAn%";
    flags = "-+ #0'";
    mods  = "lLhzjtq";
    repeat ($urandom_range(1, 6)) begin
      r = $urandom_range(0, 99);
      if (r < 30) begin
        repeat ($urandom_range(1, 4)) begin
          b = 8'($urandom_range(1, 255));
          feed_char(b == pfac_pkg::CharPct ? 8'("t") : b);
        end
      end else if (r < 88) begin
        feed_char(pfac_pkg::CharPct);
        repeat ($urandom_range(0, 2)) feed_char(flags[$urandom_range(0, flags.len()-1)]);
        case ($urandom_range(0, 2))
          1: repeat ($urandom_range(1, 2))
               feed_char(8'(pfac_pkg::CharDigLo + $urandom_range(0, 9)));
          2: feed_char(pfac_pkg::CharStar);
          default: ;
        endcase
        case ($urandom_range(0, 3))
          1: begin
            feed_char(pfac_pkg::CharDot);
            repeat ($urandom_range(1, 2))
              feed_char(8'(pfac_pkg::CharDigLo + $urandom_range(0, 9)));
          end
          2: begin
            feed_char(pfac_pkg::CharDot);
            feed_char(pfac_pkg::CharStar);
          end
          3: feed_char(pfac_pkg::CharDot);
          default: ;
        endcase
        r = $urandom_range(0, 11);
        if (r < 7) begin
          feed_char(mods[r]);
        end else if (r == 7) begin
          feed_char(pfac_pkg::CharLong);
          feed_char(pfac_pkg::CharLong);
        end else if (r == 8) begin
          feed_char("h");
          feed_char("h");
        end
        if ($urandom_range(0, 9) == 0) begin
          feed_char(8'($urandom_range(1, 255)));
        end else begin
          feed_char(convs[$urandom_range(0, convs.len()-1)]);
        end
      end else begin
        feed_char(8'($urandom_range(0, 255)));
      end
    end
    feed_char(pfac_pkg::CharNul);
  endtask

  // --------------------------------------------------------------------------
  // Receiver side: check each record, then decide the next tready
  // --------------------------------------------------------------------------

  task automatic check_record(input fmt_rec_t got);
    fmt_rec_t want;
    if (pending_recs.size() == 0) begin
      $error("unexpected record: kind %0d type %0d pos %0d", got.kind, got.arg, got.pos);
      mismatches++;
      return;
    end
    want = pending_recs.pop_front();
    if (got.kind !== want.kind) begin
      $error("record_kind: expected %0d, got %0d", want.kind, got.kind);
      mismatches++;
    end
    if (got.arg !== want.arg) begin
      $error("arg_type: expected %0d, got %0d", want.arg, got.arg);
      mismatches++;
    end
    if (got.lng !== want.lng) begin
      $error("long_flag: expected %0d, got %0d", want.lng, got.lng);
      mismatches++;
    end
    if (got.pos !== want.pos) begin
      $error("position: expected %0d, got %0d", want.pos, got.pos);
      mismatches++;
    end
    if (got.stored !== want.stored) begin
      $error("stored: expected %0d, got %0d", want.stored, got.stored);
      mismatches++;
    end
    if (got.last !== want.last) begin
      $error("last_result: expected %0d, got %0d", want.last, got.last);
      mismatches++;
    end
  endtask

  always @(posedge clk_i) begin : take_record
    fmt_rec_t seen;
    if (m_axis_tvalid && m_axis_tready) begin
      seen = '{kind: m_axis_tuser, arg: m_axis_tdata[2:0], lng: m_axis_tdata[3],
               pos: m_axis_tdata[19:4], stored: m_axis_tdata[20], last: m_axis_tlast};
      check_record(seen);
    end
    // a requested hold-off keeps tready low long enough to fill the block
    if (hold_left > 0) begin
      m_axis_tready <= 1'b0;
      hold_left--;
    end else if (hold_req) begin
      hold_req = 1'b0;
      hold_left = HoldOff - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= steady || ($urandom_range(0, 99) >= 29);
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------

  initial begin
    logic [15:0] batch_caps [5];
    int          start;
    bit          held;
    bit          paused;
    held   = 1'b0;
    paused = 1'b0;
    batch_caps = '{16'hffff, 16'h0000, 16'h0001, 16'h0003, 16'($urandom)};

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed table; typed rows replace the parser's records with their own
    load_max_types(16'd2);
    foreach (dir_plan[i]) begin
      feed_char(dir_plan[i].ch);
      if (dir_plan[i].typed) begin
        repeat (n_step) void'(pending_recs.pop_back());
        pending_recs.push_back(dir_plan[i].r0);
        if (dir_plan[i].n_recs == 2'd2) pending_recs.push_back(dir_plan[i].r1);
      end
    end

    // random batches, one max_types setting each
    for (int p = 0; p < 5; p++) begin
      load_max_types(batch_caps[p]);
      steady = (p == 2);
      start  = n_sent;
      while (n_sent - start < BatchLen) begin
        if (p == 1 && !held && n_sent - start > 30) begin
          hold_req = 1'b1;
          held     = 1'b1;
        end
        if (p == 3 && !paused && n_sent - start > 60) begin
          settle();
          paused = 1'b1;
        end
        send_format();
      end
    end
    steady = 1'b0;

    s_axis_tvalid <= 1'b0;
    while (pending_recs.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // A correct run takes a few tens of microseconds even with idling and the
  // long hold-off; allow many times that.
  initial begin
    #(2_000_000);
    $display("Mismatches found");
    $finish;
  end

endmodule
